>>> src/fpa_pkg.sv
// Package for the fixed-point ALU: command codes and the beat carried along the divider chain.
// No dependencies.
package fpa_pkg;

    localparam logic [3:0] CMD_ADD      = 4'd0;
    localparam logic [3:0] CMD_SUB      = 4'd1;
    localparam logic [3:0] CMD_MUL      = 4'd2;
    localparam logic [3:0] CMD_DIV      = 4'd3;
    localparam logic [3:0] CMD_INC      = 4'd4;
    localparam logic [3:0] CMD_DEC      = 4'd5;
    localparam logic [3:0] CMD_MIN      = 4'd6;
    localparam logic [3:0] CMD_MAX      = 4'd7;
    localparam logic [3:0] CMD_TO_INT   = 4'd8;
    localparam logic [3:0] CMD_FROM_INT = 4'd9;

    // Side information that rides with each beat down the chain.
    typedef struct packed {
        logic        valid;
        logic [3:0]  command;
        logic        less;
        logic        equal;
        logic        greater;
        logic        neg;
        logic        div_zero;
        logic        early_ovf;
        logic [31:0] early_result;
    } fpa_ctl_t;

endpackage

>>> src/fpa_div_cell.sv
// One restoring-division cell: shifts in one numerator bit, retires one quotient bit.
// Depends on fpa_pkg.
module fpa_div_cell #(
    parameter int W  = 32,
    parameter int NW = 40,
    parameter int QW = 40
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               adv,
    input  fpa_pkg::fpa_ctl_t  ctl_in,
    input  logic [W-1:0]       d_in,
    input  logic [NW-1:0]      n_in,
    input  logic [W:0]         r_in,
    input  logic [QW-1:0]      q_in,
    output fpa_pkg::fpa_ctl_t  ctl_out,
    output logic [W-1:0]       d_out,
    output logic [NW-1:0]      n_out,
    output logic [W:0]         r_out,
    output logic [QW-1:0]      q_out
);
    logic [W+1:0] shifted;
    logic [W+1:0] diff;
    logic         take;
    fpa_pkg::fpa_ctl_t ctl_reg;
    logic [W-1:0]  d_reg;
    logic [NW-1:0] n_reg;
    logic [W:0]    r_reg;
    logic [QW-1:0] q_reg;

    always_comb
    begin
        shifted = {r_in, n_in[NW-1]};
        diff    = shifted - {2'b00, d_in};
        take    = (shifted >= {2'b00, d_in});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else if (adv)
        begin
            ctl_reg <= ctl_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            d_reg <= d_in;
            n_reg <= {n_in[NW-2:0], 1'b0};
            r_reg <= take ? diff[W:0] : shifted[W:0];
            q_reg <= {q_in[QW-2:0], take};
        end
    end

    assign ctl_out = ctl_reg;
    assign d_out   = d_reg;
    assign n_out   = n_reg;
    assign r_out   = r_reg;
    assign q_out   = q_reg;
endmodule

>>> src/fixed_point_alu.sv
// Fixed-point ALU top level: front stage, a chain of division cells, a rounding stage.
// Every command takes the same path; one beat accepted per cycle while the chain is not stalled.
// The divider chain retires one quotient bit per cell; multiply rides alongside in a delay line.
// The chain stalls as a whole when the output beat is not taken.
// Reset clears all valid flags and the side-information registers; the data payload registers are not reset.
// Depends on fpa_pkg and fpa_div_cell.
module fixed_point_alu #(
    parameter int FRAC       = 8,
    parameter int WORD_WIDTH = 32
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [3:0]         command,
    input  logic signed [31:0] operand_a,
    input  logic signed [31:0] operand_b,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [31:0] result,
    output logic               less,
    output logic               equal,
    output logic               greater,
    output logic               divide_by_zero,
    output logic               overflow
);
    localparam int W   = WORD_WIDTH;
    localparam int NW  = W + FRAC;
    localparam int QW  = W + FRAC + 1;
    localparam int NC  = NW;
    localparam int MW  = (2*W + 1 > QW + 1) ? 2*W + 1 : QW + 1;
    localparam logic [W-1:0] SMIN = {1'b1, {(W-1){1'b0}}};
    localparam logic [W-1:0] SMAX = {1'b0, {(W-1){1'b1}}};

    logic adv;
    logic [W-1:0] a, b;
    logic [W-1:0] ma, mb;
    logic lt, gt, eq;
    fpa_pkg::fpa_ctl_t ctl0;
    logic [W-1:0] r0;
    logic ov0;
    logic [W:0] s_add;
    logic [W-1:0] ashr;

    always_comb
    begin
        if (W <= 32)
        begin
            a = operand_a[W-1:0];
            b = operand_b[W-1:0];
        end
        else
        begin
            a = W'(operand_a);
            b = W'(operand_b);
        end
    end

    assign ma = a[W-1] ? (~a + W'(1)) : a;
    assign mb = b[W-1] ? (~b + W'(1)) : b;
    assign lt = $signed(a) < $signed(b);
    assign gt = $signed(a) > $signed(b);
    assign eq = (a == b);
    assign ashr = W'($signed(a) >>> FRAC);

    // Front-stage results for every command except multiply and divide.
    always_comb
    begin
        logic [W-1:0] opb;
        logic         sub;
        logic         sa, sb;
        r0  = '0;
        ov0 = 1'b0;
        sub = (command == fpa_pkg::CMD_SUB) || (command == fpa_pkg::CMD_DEC);
        opb = ((command == fpa_pkg::CMD_INC) || (command == fpa_pkg::CMD_DEC)) ? W'(1) : b;
        s_add = sub ? ({1'b0, a} - {1'b0, opb}) : ({1'b0, a} + {1'b0, opb});
        sa = a[W-1];
        sb = sub ? ~opb[W-1] : opb[W-1];
        case (command)
            fpa_pkg::CMD_ADD, fpa_pkg::CMD_SUB, fpa_pkg::CMD_INC, fpa_pkg::CMD_DEC:
            begin
                r0 = s_add[W-1:0];
                if (sa == sb && s_add[W-1] != sa)
                begin
                    ov0 = 1'b1;
                    r0  = sa ? SMIN : SMAX;
                end
            end
            fpa_pkg::CMD_MIN: r0 = lt ? a : b;
            fpa_pkg::CMD_MAX: r0 = gt ? a : b;
            fpa_pkg::CMD_TO_INT: r0 = ashr;
            fpa_pkg::CMD_FROM_INT:
            begin
                r0 = W'(a << FRAC);
                if ((a[W-1] == 1'b0 && ma > (SMAX >> FRAC))
                    || (a[W-1] == 1'b1 && ma > (SMIN >> FRAC)))
                begin
                    ov0 = 1'b1;
                    r0  = a[W-1] ? SMIN : SMAX;
                end
            end
            default: r0 = '0;
        endcase
    end

    always_comb
    begin
        ctl0.valid        = in_valid;
        ctl0.command      = command;
        ctl0.less         = lt;
        ctl0.equal        = eq;
        ctl0.greater      = gt;
        ctl0.neg          = a[W-1] ^ b[W-1];
        ctl0.div_zero     = (command == fpa_pkg::CMD_DIV) && (b == '0);
        ctl0.early_ovf    = ov0;
        ctl0.early_result = 32'(signed'(r0));
    end

    // Multiply: register the magnitudes, then the product rides a delay line.
    logic [W-1:0] mag_a_reg, mag_b_reg;
    logic [2*W-1:0] prod;
    assign prod = mag_a_reg * mag_b_reg;

    fpa_pkg::fpa_ctl_t ctl [NC+1];
    logic [W-1:0]  dd [NC+1];
    logic [NW-1:0] nn [NC+1];
    logic [W:0]    rr [NC+1];
    logic [QW-1:0] qq [NC+1];
    logic [2*W-1:0] prod_line_reg [NC];

    fpa_pkg::fpa_ctl_t ctl1_reg;
    logic [NW-1:0] num1_reg;
    logic [W-1:0] div1_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ctl1_reg <= '0;
        else if (adv)
            ctl1_reg <= ctl0;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            mag_a_reg <= ma;
            mag_b_reg <= mb;
            num1_reg  <= {ma, {FRAC{1'b0}}};
            div1_reg  <= mb;
        end
    end

    assign ctl[0] = ctl1_reg;
    assign dd[0]  = div1_reg;
    assign nn[0]  = num1_reg;
    assign rr[0]  = '0;
    assign qq[0]  = '0;

    genvar gi;
    generate
        for (gi = 0; gi < NC; gi++)
        begin : g_cell
            fpa_div_cell #(.W(W), .NW(NW), .QW(QW)) u_cell (
                .clk(clk), .rst_n(rst_n), .adv(adv),
                .ctl_in(ctl[gi]), .d_in(dd[gi]), .n_in(nn[gi]), .r_in(rr[gi]),
                .q_in(qq[gi]),
                .ctl_out(ctl[gi+1]), .d_out(dd[gi+1]), .n_out(nn[gi+1]),
                .r_out(rr[gi+1]), .q_out(qq[gi+1])
            );
            if (gi == 0)
            begin : g_head
                always_ff @(posedge clk)
                begin
                    if (adv)
                        prod_line_reg[gi] <= prod;
                end
            end
            else
            begin : g_tail
                always_ff @(posedge clk)
                begin
                    if (adv)
                        prod_line_reg[gi] <= prod_line_reg[gi-1];
                end
            end
        end
    endgenerate

    // Final stage: round, saturate, select.
    fpa_pkg::fpa_ctl_t cf;
    logic [2*W-1:0] pr;
    logic [2*W:0] pr_r;
    logic [QW:0] qr;
    logic [W+1:0] rem2;
    logic [MW-1:0] mag;
    logic [W-1:0] fin;
    logic fov;

    assign cf = ctl[NC];
    assign pr = prod_line_reg[NC-1];

    always_comb
    begin
        logic [MW-1:0] lim;
        pr_r = ({1'b0, pr} + ((2*W+1)'(1) << (FRAC - 1))) >> FRAC;
        rem2 = {rr[NC], 1'b0};
        qr   = {1'b0, qq[NC]} + ((rem2 >= {2'b00, dd[NC]}) ? (QW+1)'(1) : (QW+1)'(0));
        mag  = (cf.command == fpa_pkg::CMD_MUL) ? MW'(pr_r) : MW'(qr);
        lim  = cf.neg ? MW'(SMIN) : MW'(SMAX);
        fov  = 1'b0;
        fin  = cf.early_result[W-1:0];
        if (cf.command == fpa_pkg::CMD_MUL || cf.command == fpa_pkg::CMD_DIV)
        begin
            if (mag > lim)
            begin
                fov = 1'b1;
                fin = lim[W-1:0];
            end
            else
            begin
                fin = cf.neg ? (~mag[W-1:0] + W'(1)) : mag[W-1:0];
            end
            if (cf.div_zero)
            begin
                fov = 1'b0;
                fin = '0;
            end
        end
        else
        begin
            fov = cf.early_ovf;
        end
    end

    logic out_valid_reg;
    logic [31:0] result_reg;
    logic less_reg, equal_reg, greater_reg, dz_reg, ovf_reg;

    assign adv = !out_valid_reg || out_ready;
    assign in_ready = adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (adv)
            out_valid_reg <= cf.valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            result_reg  <= 32'(signed'(fin));
            less_reg    <= cf.less;
            equal_reg   <= cf.equal;
            greater_reg <= cf.greater;
            dz_reg      <= cf.div_zero;
            ovf_reg     <= fov;
        end
    end

    assign out_valid      = out_valid_reg;
    assign result         = result_reg;
    assign less           = less_reg;
    assign equal          = equal_reg;
    assign greater        = greater_reg;
    assign divide_by_zero = dz_reg;
    assign overflow       = ovf_reg;
endmodule

>>> src/fixed_point_alu_checker.sv
// Port-level checks for the fixed-point ALU, bound to the top level.
// Depends on fixed_point_alu.
module fixed_point_alu_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [31:0] result,
    input logic        less,
    input logic        equal,
    input logic        greater,
    input logic        divide_by_zero,
    input logic        overflow
);
    a_flags_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> $onehot({less, equal, greater}))
        else $error("comparison flags not one-hot");

    a_dz_excl: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && divide_by_zero |-> !overflow && result == 32'd0)
        else $error("divide by zero with nonzero result or overflow");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(result))
        else $error("stalled output beat changed");

    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled with empty output");
endmodule

bind fixed_point_alu fixed_point_alu_checker u_checker (
    .clk(clk), .rst_n(rst_n), .in_ready(in_ready), .out_valid(out_valid),
    .out_ready(out_ready), .result(result), .less(less), .equal(equal),
    .greater(greater), .divide_by_zero(divide_by_zero), .overflow(overflow)
);
